// ===== rtl/anchor_box_generator_defines.svh =====
// Assertion macros shared by the anchor box generator checker.
`ifndef ANCHOR_BOX_GENERATOR_DEFINES_SVH
`define ANCHOR_BOX_GENERATOR_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define ABG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ABG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/abg_pkg.sv =====
// Types and constants shared by the anchor box generator modules.
package abg_pkg;

  localparam int unsigned BASE_W  = 11;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned DIV_W   = 36;
  localparam int unsigned SQ_W    = 18;
  localparam int unsigned SQ_REM_W = 20;
  localparam int unsigned COORD_W = 28;
  localparam logic [BASE_W-1:0] BASE_RESET = 11'd16;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [SCALE_W-1:0] scale;
    logic               last;
  } side_t;

endpackage

// ===== rtl/abg_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module abg_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [abg_pkg::DIV_W-1:0]   num_i,
  input  abg_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [abg_pkg::DIV_W-1:0]   quo_o,
  output abg_pkg::side_t              side_o
);

  localparam int unsigned N = abg_pkg::DIV_W;
  localparam int unsigned R = abg_pkg::RATIO_W;

  logic                 v_q   [N];
  logic [R-1:0]         rem_q [N];
  logic [N-1:0]         num_q [N];
  abg_pkg::side_t       side_q[N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic           v_in;
    logic [R-1:0]   rem_in;
    logic [N-1:0]   num_in;
    abg_pkg::side_t side_in;
    logic [R:0]     rem_sh;
    logic           take;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign num_in  = num_q[g-1];
      assign side_in = side_q[g-1];
    end

    // The quotient bits shift into the low end as the dividend leaves the top.
    assign rem_sh = {rem_in, num_in[N-1]};
    assign take   = rem_sh >= {1'b0, side_in.ratio};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= take ? R'(rem_sh - {1'b0, side_in.ratio}) : rem_sh[R-1:0];
        num_q[g]  <= {num_in[N-2:0], take};
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = num_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== rtl/abg_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module abg_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [abg_pkg::DIV_W-1:0]   val_i,
  input  abg_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [abg_pkg::SQ_W-1:0]    root_o,
  output abg_pkg::side_t              side_o
);

  localparam int unsigned N  = abg_pkg::SQ_W;
  localparam int unsigned V  = abg_pkg::DIV_W;
  localparam int unsigned RW = abg_pkg::SQ_REM_W;

  logic            v_q   [N];
  logic [RW-1:0]   rem_q [N];
  logic [N-1:0]    root_q[N];
  logic [V-1:0]    val_q [N];
  abg_pkg::side_t  side_q[N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic           v_in;
    logic [RW-1:0]  rem_in;
    logic [N-1:0]   root_in;
    logic [V-1:0]   val_in;
    abg_pkg::side_t side_in;
    logic [RW+1:0]  rem_sh;
    logic [RW+1:0]  trial;
    logic           take;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign val_in  = val_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign rem_sh = {rem_in, val_in[V-1:V-2]};
    assign trial  = (RW+2)'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= take ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
        root_q[g] <= {root_in[N-2:0], take};
        val_q[g]  <= {val_in[V-3:0], 2'b00};
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== rtl/abg_corner.sv =====
// Side lengths, half extents and saturated corner coordinates in four stages.
module abg_corner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [abg_pkg::SQ_W-1:0]      root_i,
  input  abg_pkg::side_t                side_i,
  input  logic [abg_pkg::BASE_W-1:0]    win_side_i,
  output logic                          valid_o,
  output logic [abg_pkg::COORD_W-1:0]   x_min_o,
  output logic [abg_pkg::COORD_W-1:0]   y_min_o,
  output logic [abg_pkg::COORD_W-1:0]   x_max_o,
  output logic [abg_pkg::COORD_W-1:0]   y_max_o,
  output logic                          last_o,
  output logic                          sat_o
);

  localparam int unsigned CW = abg_pkg::COORD_W;
  localparam int unsigned SW = 42;
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [SW-1:0] CMIN = -SW'(64'sd1 <<< (CW-1));

  function automatic logic [CW:0] clamp(input logic signed [SW-1:0] v);
    logic [CW:0] r;
    if (v > CMAX) begin
      r = {1'b1, CMAX[CW-1:0]};
    end else if (v < CMIN) begin
      r = {1'b1, CMIN[CW-1:0]};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

  logic [3:0]  v_q;
  abg_pkg::side_t side_a_q, side_b_q, side_c_q;
  logic [33:0] wr_q, ws_q;
  logic [21:0] h_q;
  logic [28:0] pw_b_q, pw_c_q;
  logic [37:0] hs_q;

  logic [17:0] w;
  logic [34:0] wr_rnd, ws_rnd;
  logic [38:0] hs_rnd;
  logic [33:0] ph;
  logic signed [SW-1:0] base8, xmn, ymn, xmx, ymx;
  logic [CW:0] cx0, cy0, cx1, cy1;

  // Stage A: rounded width and the two products that depend on it.
  assign w = 18'((19'(root_i) + 19'd1) >> 1);

  // Stage B: rounded height and horizontal half extent.
  assign wr_rnd = 35'(wr_q) + 35'd2048;
  assign ws_rnd = 35'(ws_q) + 35'd16;

  // Stage D: vertical half extent and the corners.
  assign hs_rnd = 39'(hs_q) + 39'd16;
  assign ph     = hs_rnd[38:5];
  assign base8  = SW'({win_side_i, 3'b000});
  assign xmn = base8 - SW'(pw_c_q);
  assign ymn = base8 - SW'(ph);
  assign xmx = base8 - SW'(16) + SW'(pw_c_q);
  assign ymx = base8 - SW'(16) + SW'(ph);
  assign cx0 = clamp(xmn);
  assign cy0 = clamp(ymn);
  assign cx1 = clamp(xmx);
  assign cy1 = clamp(ymx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wr_q     <= 34'(w) * 34'(side_i.ratio);
      ws_q     <= 34'(w) * 34'(side_i.scale);
      side_a_q <= side_i;
      h_q      <= wr_rnd[33:12];
      pw_b_q   <= ws_rnd[33:5];
      side_b_q <= side_a_q;
      hs_q     <= 38'(h_q) * 38'(side_b_q.scale);
      pw_c_q   <= pw_b_q;
      side_c_q <= side_b_q;
      x_min_o  <= cx0[CW-1:0];
      y_min_o  <= cy0[CW-1:0];
      x_max_o  <= cx1[CW-1:0];
      y_max_o  <= cy1[CW-1:0];
      sat_o    <= cx0[CW] | cy0[CW] | cx1[CW] | cy1[CW];
      last_o   <= side_c_q.last;
    end
  end

  assign valid_o = v_q[3];

endmodule

// ===== rtl/anchor_box_generator.sv =====
// Top level of the anchor box generator: stream ports, base register, pipeline.
// The anchor box generator turns each (ratio, scale) word into one anchor box
// around the center of a square base window whose side is win_side pixels.
// The width is round(sqrt(win_side^2 / ratio)), the height is
// round(width * ratio), both scaled by scale, and the four corners come out
// in signed Q.4 fixed point, clipped to 28 bits with tuser flagging a clip.
// The block is fully pipelined and takes one word every cycle while the
// output is not stalled: a register forms the dividend, a 36-stage divider
// produces win_side^2 * 2^14 / ratio, an 18-stage square root follows, and
// four stages of multiply, round and clamp finish the corners, the last of
// them being the output register. All stages share one enable, so when the
// output word is not taken the whole pipeline holds and nothing is dropped
// or repeated. A ratio of zero is treated as the smallest nonzero ratio.
// win_side must only be written while no word is in flight; it resets to 16.
module anchor_box_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         win_side_we_i,
  input  logic [abg_pkg::BASE_W-1:0]   win_side_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0: ratio[15:0], scale[31:16].
  input  logic [31:0]                  s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0: x_min[27:0], y_min[55:28], x_max[83:56], y_max[111:84].
  output logic [111:0]                 m_axis_tdata_o,
  output logic                         m_axis_tlast_o,
  // Fields from bit 0: saturated[0].
  output logic                         m_axis_tuser_o
);

  logic [abg_pkg::BASE_W-1:0] base_q;
  logic                       en;
  logic                       in_v_q;
  logic [abg_pkg::DIV_W-1:0]  num_q;
  abg_pkg::side_t             side_in, side_q, div_side, sq_side;
  logic                       div_v, sq_v;
  logic [abg_pkg::DIV_W-1:0]  quo;
  logic [abg_pkg::SQ_W-1:0]   root;
  logic [21:0]                b_sq;

  // The pipeline advances whenever the output register is empty or drained.
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= abg_pkg::BASE_RESET;
    end else if (win_side_we_i) begin
      base_q <= win_side_i;
    end
  end

  assign side_in.ratio = (s_axis_tdata_i[15:0] == '0) ? 16'd1 : s_axis_tdata_i[15:0];
  assign side_in.scale = s_axis_tdata_i[31:16];
  assign side_in.last  = s_axis_tlast_i;
  assign b_sq          = 22'(base_q) * 22'(base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  // Dividend is 4 * B^2 * 4096, so the low fourteen bits are zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= {b_sq, 14'd0};
      side_q <= side_in;
    end
  end

  abg_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .num_i   (num_q),
    .side_i  (side_q),
    .valid_o (div_v),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  abg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v),
    .val_i   (quo),
    .side_i  (div_side),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  abg_corner u_corner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (sq_v),
    .root_i      (root),
    .side_i      (sq_side),
    .win_side_i  (base_q),
    .valid_o     (m_axis_tvalid_o),
    .x_min_o     (m_axis_tdata_o[27:0]),
    .y_min_o     (m_axis_tdata_o[55:28]),
    .x_max_o     (m_axis_tdata_o[83:56]),
    .y_max_o     (m_axis_tdata_o[111:84]),
    .last_o      (m_axis_tlast_o),
    .sat_o       (m_axis_tuser_o)
  );

endmodule

// ===== rtl/abg_checker.sv =====
// Port-level checker for the anchor box generator and its bind.
`include "anchor_box_generator_defines.svh"

module abg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [111:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  localparam logic [27:0] CMAX = 28'h7FFFFFF;
  localparam logic [27:0] CMIN = 28'h8000000;

  logic signed [29:0] xmn, xmx;
  logic               rail_hit;
  logic               ready_ok;

  assign xmn = 30'(signed'(m_axis_tdata_o[27:0]));
  assign xmx = 30'(signed'(m_axis_tdata_o[83:56]));

  // Some corner sits on either end of the coordinate range.
  assign rail_hit = (m_axis_tdata_o[27:0] == CMIN) || (m_axis_tdata_o[27:0] == CMAX) ||
                    (m_axis_tdata_o[55:28] == CMIN) || (m_axis_tdata_o[55:28] == CMAX) ||
                    (m_axis_tdata_o[83:56] == CMIN) || (m_axis_tdata_o[83:56] == CMAX) ||
                    (m_axis_tdata_o[111:84] == CMIN) || (m_axis_tdata_o[111:84] == CMAX);

  // Case equality so the relation also holds before reset settles the valid bit.
  assign ready_ok = s_axis_tready_o === (!m_axis_tvalid_o || m_axis_tready_i);

  `ABG_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "output word dropped while stalled")
  `ABG_ASSERT_ALWAYS(a_ready, clk_i, ready_ok, "input ready does not follow output drain")
  `ABG_ASSERT(a_sat, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> rail_hit, "saturation flag without a clipped corner")
  `ABG_ASSERT(a_order, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o |-> (xmn <= xmx + 30'sd16), "right corner left of left corner")

endmodule

bind anchor_box_generator abg_checker u_abg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
